// ----- sv/rfc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the response frame checker.
`default_nettype none

package rfc_pkg;

    localparam int unsigned MAX_RESPONSE = 72;
    localparam int unsigned MIN_RESPONSE = 4;
    localparam int unsigned STATUS_COUNT = 4;
    localparam int unsigned CRC_BYTES    = 2;
    localparam logic [15:0] CRC_POLY     = 16'h8005;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_BAD_COUNT = 2'd1,
        VERDICT_CRC_ERROR = 2'd2,
        VERDICT_TRUNCATED = 2'd3
    } t_verdict;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] data_byte;
        t_verdict   verdict;
        logic       status_flag;
        logic [7:0] status_code;
        logic [6:0] payload_length;
        logic       last;
    } t_result;

    // Up to two results per input transfer; slot 1 is used only with slot 0.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    // Data bits enter LSB first into a register that shifts MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb = b[k] ^ c[15];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rfc_core.sv -----
// Input register, frame state, CRC and verdict logic of the response frame checker.
`default_nettype none

module rfc_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [7:0]       i_byte,
    input  wire              i_start,
    input  wire              i_room,
    output rfc_pkg::t_push   o_push
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    logic        r_in_frame, n_in_frame;
    logic [6:0]  r_exp_cnt, n_exp_cnt;
    logic [6:0]  r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [7:0]  r_first, n_first;

    logic        advance;
    logic        bad_count;
    logic [7:0]  pos_plus2;
    logic [7:0]  cnt8;
    logic [15:0] got_crc;
    rfc_pkg::t_result res_trunc, res_bad, res_one;

    assign advance = r_in_valid && i_room;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_byte;
            r_in_start <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_exp_cnt  <= '0;
            r_pos      <= '0;
            r_crc      <= '0;
            r_crc_lo   <= '0;
            r_first    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_exp_cnt  <= n_exp_cnt;
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_crc_lo   <= n_crc_lo;
            r_first    <= n_first;
        end
    end

    always_comb begin
        bad_count = (r_in_byte < 8'(rfc_pkg::MIN_RESPONSE))
                 || (r_in_byte > 8'(rfc_pkg::MAX_RESPONSE));
        pos_plus2 = {1'b0, r_pos} + 8'(rfc_pkg::CRC_BYTES);
        cnt8      = {1'b0, r_exp_cnt};
        got_crc   = {r_in_byte, r_crc_lo};

        res_trunc           = '0;
        res_trunc.item_kind = rfc_pkg::KIND_VERDICT;
        res_trunc.verdict   = rfc_pkg::VERDICT_TRUNCATED;
        res_trunc.last      = 1'b1;

        res_bad         = res_trunc;
        res_bad.verdict = rfc_pkg::VERDICT_BAD_COUNT;

        res_one = '0;

        n_in_frame = r_in_frame;
        n_exp_cnt  = r_exp_cnt;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_crc_lo   = r_crc_lo;
        n_first    = r_first;

        o_push    = '0;
        o_push.r1 = res_bad;

        if (advance) begin
            if (r_in_start) begin
                // truncated verdict first, then the byte is a new count
                o_push.v0  = r_in_frame || bad_count;
                o_push.v1  = r_in_frame && bad_count;
                o_push.r0  = r_in_frame ? res_trunc : res_bad;
                n_in_frame = !bad_count;
                if (!bad_count) begin
                    n_exp_cnt = r_in_byte[6:0];
                    n_pos     = 7'd1;
                    n_crc     = rfc_pkg::crc_feed(16'h0000, r_in_byte);
                    n_crc_lo  = '0;
                    n_first   = '0;
                end
            end else if (r_in_frame) begin
                if (pos_plus2 < cnt8) begin
                    n_crc = rfc_pkg::crc_feed(r_crc, r_in_byte);
                    if (r_pos == 7'd1) begin
                        n_first = r_in_byte;
                    end
                    // status octet of a status frame is held, not forwarded
                    res_one.item_kind = rfc_pkg::KIND_PAYLOAD;
                    res_one.data_byte = r_in_byte;
                    o_push.v0 = (r_exp_cnt != 7'(rfc_pkg::STATUS_COUNT));
                    o_push.r0 = res_one;
                    n_pos     = r_pos + 7'd1;
                end else if (pos_plus2 == cnt8) begin
                    n_crc_lo = r_in_byte;
                    n_pos    = r_pos + 7'd1;
                end else begin
                    res_one.item_kind = rfc_pkg::KIND_VERDICT;
                    res_one.last      = 1'b1;
                    if (got_crc == r_crc) begin
                        res_one.verdict = rfc_pkg::VERDICT_OK;
                        if (r_exp_cnt == 7'(rfc_pkg::STATUS_COUNT)) begin
                            res_one.status_flag = 1'b1;
                            res_one.status_code = r_first;
                        end else begin
                            res_one.payload_length = r_exp_cnt - 7'd3;
                        end
                    end else begin
                        res_one.verdict = rfc_pkg::VERDICT_CRC_ERROR;
                    end
                    o_push.v0  = 1'b1;
                    o_push.r0  = res_one;
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/rfc_fifo.sv -----
// Result queue that takes up to two results per cycle and hands out one.
`default_nettype none

module rfc_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  rfc_pkg::t_push     i_push,
    output logic               o_room,
    output logic               o_valid,
    input  wire                i_ready,
    output rfc_pkg::t_result   o_result
);

    rfc_pkg::t_result r_mem [rfc_pkg::FIFO_DEPTH];
    logic [rfc_pkg::PTR_W-1:0] r_wr, r_rd;
    logic [rfc_pkg::CNT_W-1:0] r_cnt;
    logic [rfc_pkg::PTR_W-1:0] wr_next;
    logic [rfc_pkg::CNT_W-1:0] n_push;
    logic                      pop;

    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_cnt != '0);
    assign o_result = r_mem[r_rd];
    // keep space for the largest burst one transfer can cause
    assign o_room   = (r_cnt <= rfc_pkg::CNT_W'(rfc_pkg::FIFO_DEPTH - 2));
    assign wr_next  = r_wr + rfc_pkg::PTR_W'(1);
    assign n_push   = rfc_pkg::CNT_W'(i_push.v0) + rfc_pkg::CNT_W'(i_push.v1);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_next] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + rfc_pkg::PTR_W'(n_push);
            r_rd  <= r_rd + rfc_pkg::PTR_W'(pop);
            r_cnt <= r_cnt + n_push - rfc_pkg::CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ----- sv/response_frame_checker.sv -----
// Top level of the response frame checker: CRC-16 length-prefixed frame check.
// Each input transfer is registered, then its results are written to the result queue when it has room;
// a second result follows the first. Throughput: one input byte per cycle, set by the CRC byte update
// and by the result queue, which accepts input only while room for two results remains.
// A start byte that truncates a frame and is itself a bad count yields two results.
// Reset (i_rst_n low, synchronous) clears frame state and empties the result queue.
`default_nettype none

module response_frame_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  wire         i_s_axis_tuser,   // [0] frame_start
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] data_byte, [9:8] verdict, [10] status_flag,
                                          // [18:11] status_code, [25:19] payload_length
    output logic        o_m_axis_tuser,   // [0] item_kind
    output logic        o_m_axis_tlast
);

    rfc_pkg::t_push   push;
    rfc_pkg::t_result result;
    logic             room;

    rfc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_start (i_s_axis_tuser),
        .i_room  (room),
        .o_push  (push)
    );

    rfc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {6'd0, result.payload_length, result.status_code,
                             result.status_flag, result.verdict, result.data_byte};
    assign o_m_axis_tuser = result.item_kind;
    assign o_m_axis_tlast = result.last;

endmodule

`default_nettype wire

// ----- tb/tb_response_frame_checker.sv -----
// Self-checking testbench for the response frame checker: directed frames, then random traffic.
`timescale 1ns / 100ps

module tb_response_frame_checker;

    localparam int unsigned MIN_RESPONSE = rfc_pkg::MIN_RESPONSE;
    localparam int unsigned MAX_RESPONSE = rfc_pkg::MAX_RESPONSE;
    localparam int unsigned STATUS_COUNT = rfc_pkg::STATUS_COUNT;
    localparam logic        KIND_PAYLOAD = rfc_pkg::KIND_PAYLOAD;
    localparam logic        KIND_VERDICT = rfc_pkg::KIND_VERDICT;

    localparam rfc_pkg::t_verdict VERDICT_OK        = rfc_pkg::VERDICT_OK;
    localparam rfc_pkg::t_verdict VERDICT_BAD_COUNT = rfc_pkg::VERDICT_BAD_COUNT;
    localparam rfc_pkg::t_verdict VERDICT_CRC_ERROR = rfc_pkg::VERDICT_CRC_ERROR;
    localparam rfc_pkg::t_verdict VERDICT_TRUNCATED = rfc_pkg::VERDICT_TRUNCATED;

    localparam int ITEM_TARGET  = 400;
    localparam int QUIET_ITEMS  = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {
        BYTE_RAW    = 2'd0,
        BYTE_CRC_LO = 2'd1,
        BYTE_CRC_HI = 2'd2
    } t_byte_src;

    // val is the octet for BYTE_RAW and an error mask for the CRC octets
    typedef struct packed {
        logic [7:0]        val;
        logic              start;
        t_byte_src         src;
        logic              typed;
        logic [1:0]        n_typed;
        rfc_pkg::t_verdict v0;
        rfc_pkg::t_verdict v1;
    } t_frame_row;

    localparam int N_ROWS = 22;
    localparam t_frame_row DIRECTED_ROWS [N_ROWS] = '{
        '{8'd0,   1'b1, BYTE_RAW,    1'b1, 2'd1, VERDICT_BAD_COUNT, VERDICT_OK},
        '{8'd3,   1'b1, BYTE_RAW,    1'b1, 2'd1, VERDICT_BAD_COUNT, VERDICT_OK},
        '{8'd73,  1'b1, BYTE_RAW,    1'b1, 2'd1, VERDICT_BAD_COUNT, VERDICT_OK},
        '{8'd255, 1'b1, BYTE_RAW,    1'b1, 2'd1, VERDICT_BAD_COUNT, VERDICT_OK},
        '{8'hAA,  1'b0, BYTE_RAW,    1'b1, 2'd0, VERDICT_OK,        VERDICT_OK},
        // status frame, good CRC
        '{8'd4,   1'b1, BYTE_RAW,    1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'hFF,  1'b0, BYTE_RAW,    1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'h00,  1'b0, BYTE_CRC_LO, 1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'h00,  1'b0, BYTE_CRC_HI, 1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        // shortest data frame, good CRC
        '{8'd5,   1'b1, BYTE_RAW,    1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'h00,  1'b0, BYTE_RAW,    1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'hFF,  1'b0, BYTE_RAW,    1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'h00,  1'b0, BYTE_CRC_LO, 1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'h00,  1'b0, BYTE_CRC_HI, 1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        // start mid-frame: once with a valid count, once with a bad one
        '{8'd4,   1'b1, BYTE_RAW,    1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'h12,  1'b0, BYTE_RAW,    1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'd72,  1'b1, BYTE_RAW,    1'b1, 2'd1, VERDICT_TRUNCATED, VERDICT_OK},
        '{8'd200, 1'b1, BYTE_RAW,    1'b1, 2'd2, VERDICT_TRUNCATED, VERDICT_BAD_COUNT},
        // status frame with a flipped CRC bit
        '{8'd4,   1'b1, BYTE_RAW,    1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'h00,  1'b0, BYTE_RAW,    1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'h00,  1'b0, BYTE_CRC_LO, 1'b0, 2'd0, VERDICT_OK,        VERDICT_OK},
        '{8'h80,  1'b0, BYTE_CRC_HI, 1'b1, 2'd1, VERDICT_CRC_ERROR, VERDICT_OK}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        i_s_axis_tuser = 1'b0;    // [0] frame_start
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;           // [7:0] data_byte, [9:8] verdict, [10] status_flag,
                                           // [18:11] status_code, [25:19] payload_length
    logic        o_m_axis_tuser;           // [0] item_kind
    logic        o_m_axis_tlast;

    response_frame_checker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Frame tracker state
    logic        frame_open  = 1'b0;
    logic [6:0]  frame_len   = '0;
    logic [6:0]  next_pos    = '0;
    logic [15:0] crc_acc     = '0;
    logic [7:0]  rx_crc_lo   = '0;
    logic [7:0]  status_byte = '0;

    rfc_pkg::t_result expected_results [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      cycles     = 0;
    int      last_yield = 0;
    bit      quiet      = 1'b0;

    function automatic logic [15:0] crc16_lsb_in(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            if (b[i] != r[15])
                r = (r << 1) ^ 16'h8005;
            else
                r = r << 1;
        end
        return r;
    endfunction

    function automatic rfc_pkg::t_result verdict_item(input rfc_pkg::t_verdict v);
        rfc_pkg::t_result r;
        r = '0;
        r.item_kind = KIND_VERDICT;
        r.verdict   = v;
        r.last      = 1'b1;
        return r;
    endfunction

    // Advance the frame tracker by one accepted octet and queue what it yields.
    task automatic predict_byte(input logic [7:0] b, input logic s, output bit skipped);
        rfc_pkg::t_result r;
        skipped = 1'b0;
        if (s) begin
            if (frame_open)
                expected_results.push_back(verdict_item(VERDICT_TRUNCATED));
            frame_open = 1'b0;
            if (b < MIN_RESPONSE || b > MAX_RESPONSE) begin
                expected_results.push_back(verdict_item(VERDICT_BAD_COUNT));
            end else begin
                frame_open  = 1'b1;
                frame_len   = b[6:0];
                next_pos    = 7'd1;
                crc_acc     = crc16_lsb_in(16'h0000, b);
                rx_crc_lo   = '0;
                status_byte = '0;
            end
        end else if (!frame_open) begin
            skipped = 1'b1;
        end else if (next_pos + 2 < frame_len) begin
            crc_acc = crc16_lsb_in(crc_acc, b);
            if (next_pos == 7'd1)
                status_byte = b;
            if (frame_len != STATUS_COUNT) begin
                r = '0;
                r.item_kind = KIND_PAYLOAD;
                r.data_byte = b;
                expected_results.push_back(r);
            end
            next_pos = next_pos + 7'd1;
        end else if (next_pos + 2 == frame_len) begin
            rx_crc_lo = b;
            next_pos  = next_pos + 7'd1;
        end else begin
            if ({b, rx_crc_lo} == crc_acc) begin
                r = verdict_item(VERDICT_OK);
                if (frame_len == STATUS_COUNT) begin
                    r.status_flag = 1'b1;
                    r.status_code = status_byte;
                end else begin
                    r.payload_length = frame_len - 7'd3;
                end
                expected_results.push_back(r);
            end else begin
                expected_results.push_back(verdict_item(VERDICT_CRC_ERROR));
            end
            frame_open = 1'b0;
            next_pos   = '0;
        end
    endtask

    // Offer one octet, hold it until the transfer, then update the tracker.
    task automatic put_byte(input logic [7:0] b, input logic s);
        bit skipped;
        int sz;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= s;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sz = expected_results.size();
        predict_byte(b, s, skipped);
        last_yield = expected_results.size() - sz;
        if (!skipped)
            items_sent++;
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic send_frame();
        int          kind;
        int          len;
        int          stop_at;
        logic [7:0]  lo_mask;
        logic [7:0]  hi_mask;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(MIN_RESPONSE, MAX_RESPONSE);
            else if ($urandom_range(0, 3) == 0)
                len = STATUS_COUNT;
            else
                len = $urandom_range(MIN_RESPONSE + 1, 10);
            // truncated frames stop short and leave the tracker mid-frame
            stop_at = (kind < 68) ? len - 1 : $urandom_range(0, len - 2);
            put_byte(len[7:0], 1'b1);
            for (int p = 1; p <= stop_at && p < len - 2; p++)
                put_byte(8'($urandom_range(0, 255)), 1'b0);
            if (stop_at == len - 1) begin
                lo_mask = '0;
                hi_mask = '0;
                if ($urandom_range(0, 4) == 0) begin
                    lo_mask = 8'($urandom_range(0, 255));
                    hi_mask = 8'($urandom_range(lo_mask == 0 ? 1 : 0, 255));
                end
                put_byte(crc_acc[7:0] ^ lo_mask, 1'b0);
                put_byte(crc_acc[15:8] ^ hi_mask, 1'b0);
            end else if (stop_at == len - 2) begin
                put_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end else if (kind < 90) begin
            if ($urandom_range(0, 1) == 0)
                put_byte(8'($urandom_range(0, MIN_RESPONSE - 1)), 1'b1);
            else
                put_byte(8'($urandom_range(MAX_RESPONSE + 1, 255)), 1'b1);
        end else begin
            repeat ($urandom_range(1, 3))
                put_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // Result monitor
    always @(posedge i_clk) begin
        rfc_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: tdata 0x%0h tuser %0b", o_m_axis_tdata,
                       o_m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("item_kind", want.item_kind, o_m_axis_tuser);
                check_field("data_byte", want.data_byte, o_m_axis_tdata[7:0]);
                check_field("verdict", want.verdict, o_m_axis_tdata[9:8]);
                check_field("status_flag", want.status_flag, o_m_axis_tdata[10]);
                check_field("status_code", want.status_code, o_m_axis_tdata[18:11]);
                check_field("payload_length", want.payload_length, o_m_axis_tdata[25:19]);
                check_field("last", want.last, o_m_axis_tlast);
            end
        end
    end

    // Result sink: random stalls until the quiet stretch at the end
    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_frame_row row;
        logic [7:0] b;
        bit         drained_mid;
        drained_mid = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            case (row.src)
                BYTE_CRC_LO: b = crc_acc[7:0] ^ row.val;
                BYTE_CRC_HI: b = crc_acc[15:8] ^ row.val;
                default:     b = row.val;
            endcase
            put_byte(b, row.start);
            // typed rows replace what the tracker queued with the table entry
            if (row.typed) begin
                repeat (last_yield)
                    void'(expected_results.pop_back());
                if (row.n_typed >= 1)
                    expected_results.push_back(verdict_item(row.v0));
                if (row.n_typed == 2)
                    expected_results.push_back(verdict_item(row.v1));
            end
        end
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
                drain_results();
                drained_mid = 1'b1;
            end
            quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
            send_frame();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
